// ===== src/kd14_pkg.sv =====
// kd14_pkg: shared constants and types for the 14-dop build and box overlap core
`timescale 1ns / 1ps
`default_nettype none

package kd14_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int NUM_AXES        = 7;
    localparam int NUM_COORDS      = 3;
    // axes 0..2 are x, y, z; a query takes the box interval on them as given
    localparam int NUM_PLAIN       = 3;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    // bit i set: the coordinate enters axis i; order x, y, z
    // axes: x, y, z, x+y+z, x-y+z, x+y-z, x-y-z
    localparam logic [NUM_AXES-1:0] AXIS_USE [NUM_COORDS] = '{
        7'b1111001,
        7'b1111010,
        7'b1111100
    };
    // bit i set: the coordinate enters axis i with a minus sign
    localparam logic [NUM_AXES-1:0] AXIS_NEG [NUM_COORDS] = '{
        7'b0000000,
        7'b1010000,
        7'b1100000
    };

    typedef struct packed {
        logic       valid;
        logic [1:0] op;
    } kd14_ctrl_t;

endpackage

`default_nettype wire

// ===== src/kd14_if.sv =====
// kd14_if: valid/ready channels for input items and overlap results
`timescale 1ns / 1ps
`default_nettype none

interface kd14_in_if
    import kd14_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;

    modport source (
        output valid, opcode, first_x, first_y, first_z, second_x, second_y, second_z,
        input  ready
    );
    modport sink (
        input  valid, opcode, first_x, first_y, first_z, second_x, second_y, second_z,
        output ready
    );
endinterface

interface kd14_out_if;
    logic valid;
    logic ready;
    logic overlap;

    modport source (
        output valid, overlap,
        input  ready
    );
    modport sink (
        input  valid, overlap,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/kd14_proj.sv =====
// kd14_proj: input word register and projection of a point or box onto the seven axes
`timescale 1ns / 1ps
`default_nettype none

module kd14_proj
    import kd14_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int PW = COORD_WIDTH + 2
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    kd14_in_if.sink                 item,
    input  wire logic               adv,
    output kd14_ctrl_t              ctrl,
    output logic signed [PW-1:0]    lo_proj [NUM_AXES],
    output logic signed [PW-1:0]    hi_proj [NUM_AXES]
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [1:0]                    op_reg;
    logic signed [COORD_WIDTH-1:0] a_reg [NUM_COORDS];
    logic signed [COORD_WIDTH-1:0] b_reg [NUM_COORDS];
    logic                          take;

    logic signed [PW-1:0] a_ext [NUM_COORDS];
    logic signed [PW-1:0] b_ext [NUM_COORDS];
    logic signed [PW-1:0] c_min [NUM_COORDS];
    logic signed [PW-1:0] c_max [NUM_COORDS];

    assign item.ready = !valid_reg || adv;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (adv)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg   <= item.opcode;
            a_reg[0] <= item.first_x;
            a_reg[1] <= item.first_y;
            a_reg[2] <= item.first_z;
            b_reg[0] <= item.second_x;
            b_reg[1] <= item.second_y;
            b_reg[2] <= item.second_z;
        end
    end

    assign ctrl.valid = valid_reg;
    assign ctrl.op    = op_reg;

    always_comb
    begin
        for (int k = 0; k < NUM_COORDS; k++)
        begin
            a_ext[k] = PW'(a_reg[k]);
            b_ext[k] = PW'(b_reg[k]);
            c_min[k] = (a_ext[k] < b_ext[k]) ? a_ext[k] : b_ext[k];
            c_max[k] = (a_ext[k] < b_ext[k]) ? b_ext[k] : a_ext[k];
        end
    end

    // corner min/max of a diagonal splits per coordinate, so no corner sweep is needed
    always_comb
    begin
        logic signed [PW-1:0] pt_sum;
        logic signed [PW-1:0] qlo_sum;
        logic signed [PW-1:0] qhi_sum;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            pt_sum  = '0;
            qlo_sum = '0;
            qhi_sum = '0;
            for (int k = 0; k < NUM_COORDS; k++)
            begin
                if (AXIS_USE[k][i])
                begin
                    if (AXIS_NEG[k][i])
                    begin
                        pt_sum  = pt_sum - a_ext[k];
                        qlo_sum = qlo_sum - c_max[k];
                        qhi_sum = qhi_sum - c_min[k];
                    end
                    else
                    begin
                        pt_sum  = pt_sum + a_ext[k];
                        qlo_sum = qlo_sum + c_min[k];
                        qhi_sum = qhi_sum + c_max[k];
                    end
                end
            end
            if (op_reg == OP_QUERY)
            begin
                if (i < NUM_PLAIN)
                begin
                    lo_proj[i] = a_ext[i];
                    hi_proj[i] = b_ext[i];
                end
                else
                begin
                    lo_proj[i] = qlo_sum;
                    hi_proj[i] = qhi_sum;
                end
            end
            else
            begin
                lo_proj[i] = pt_sum;
                hi_proj[i] = pt_sum;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/kd14_bounds.sv =====
// kd14_bounds: bound registers, add and clear update, overlap test and result register
`timescale 1ns / 1ps
`default_nettype none

module kd14_bounds
    import kd14_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int PW = COORD_WIDTH + 2
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire kd14_ctrl_t         ctrl,
    input  wire logic signed [PW-1:0] lo_proj [NUM_AXES],
    input  wire logic signed [PW-1:0] hi_proj [NUM_AXES],
    output logic                    adv,
    kd14_out_if.source              result
);

    localparam logic signed [PW-1:0] LOW_EMPTY  = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] HIGH_EMPTY = {1'b1, {(PW-1){1'b0}}};

    logic signed [PW-1:0] low_reg   [NUM_AXES];
    logic signed [PW-1:0] high_reg  [NUM_AXES];
    logic signed [PW-1:0] low_next  [NUM_AXES];
    logic signed [PW-1:0] high_next [NUM_AXES];
    logic [NUM_AXES-1:0]  hit;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 overlap_reg;
    logic                 out_free;
    logic                 is_query;

    assign is_query = (ctrl.op == OP_QUERY);
    assign out_free = !out_valid_reg || result.ready;
    // clear and add words never wait on the result register
    assign adv      = ctrl.valid && (!is_query || out_free);

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            // touching end points count as overlapping
            hit[i]       = !((high_reg[i] < lo_proj[i]) || (low_reg[i] > hi_proj[i]));
            low_next[i]  = low_reg[i];
            high_next[i] = high_reg[i];
            if (adv)
            begin
                case (ctrl.op)
                    OP_CLEAR:
                    begin
                        low_next[i]  = LOW_EMPTY;
                        high_next[i] = HIGH_EMPTY;
                    end
                    OP_ADD:
                    begin
                        if (lo_proj[i] < low_reg[i])
                        begin
                            low_next[i] = lo_proj[i];
                        end
                        if (hi_proj[i] > high_reg[i])
                        begin
                            high_next[i] = hi_proj[i];
                        end
                    end
                    default:
                    begin
                        low_next[i]  = low_reg[i];
                        high_next[i] = high_reg[i];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                low_reg[i]  <= LOW_EMPTY;
                high_reg[i] <= HIGH_EMPTY;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                low_reg[i]  <= low_next[i];
                high_reg[i] <= high_next[i];
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv && is_query)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && is_query)
        begin
            overlap_reg <= &hit;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.overlap = overlap_reg;

`ifndef NO_ASSERTIONS
    a_adv_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        adv |-> ctrl.valid)
        else $error("word advanced with no valid word held");

    a_query_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv && is_query |=> out_valid_reg)
        else $error("query advanced without a result");

    a_other_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !is_query && out_valid_reg && !result.ready
        |=> out_valid_reg && $stable(overlap_reg))
        else $error("clear or add disturbed a waiting result");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        adv && (ctrl.op == OP_CLEAR)
        |=> (low_reg[0] == LOW_EMPTY) && (high_reg[NUM_AXES-1] == HIGH_EMPTY))
        else $error("clear left bounds set");

    a_add_orders_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        adv && (ctrl.op == OP_ADD) |=> low_reg[0] <= high_reg[0])
        else $error("bounds inverted after add");
`endif

endmodule

`default_nettype wire

// ===== src/kdop14_build_and_aabb_overlap_core.sv =====
// kdop14_build_and_aabb_overlap_core: 14-dop bound builder with box overlap query
//
//  channel  dir  handshake      payload
//  item     in   valid/ready    opcode, first_x/y/z, second_x/y/z (COORD_WIDTH each)
//  result   out  valid/ready    overlap (query words only)
//
//  one word per cycle sustained unless a query waits on a full result register; a query
//  result passes from the input register through projection and bound compare into the
//  result register. clear and add words give no result and pass a stalled result register.
//  reset empties all bounds at once and drops both valid flags.
//  a query waits in the input register only while the result register is full and
//  not being taken.
`timescale 1ns / 1ps
`default_nettype none

module kdop14_build_and_aabb_overlap_core
    import kd14_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    kd14_in_if.sink    item,
    kd14_out_if.source result
);

    localparam int PW = COORD_WIDTH + 2;

    kd14_ctrl_t           ctrl;
    logic                 adv;
    logic signed [PW-1:0] lo_proj [NUM_AXES];
    logic signed [PW-1:0] hi_proj [NUM_AXES];

    kd14_proj #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_proj (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .adv     (adv),
        .ctrl    (ctrl),
        .lo_proj (lo_proj),
        .hi_proj (hi_proj)
    );

    kd14_bounds #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_bounds (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .lo_proj (lo_proj),
        .hi_proj (hi_proj),
        .adv     (adv),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== bench/kdop14_build_and_aabb_overlap_core_tb.sv =====
// self-checking bench for the 14-dop build and box overlap core: directed and random words
`timescale 1ns / 1ps

module kdop14_build_and_aabb_overlap_core_tb;

    import kd14_pkg::*;

    localparam int CW     = 32;
    localparam int PROJ_W = CW + 2;
    localparam int NUM_CORNERS = 8;
    localparam int RANDOM_WORDS = 425;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE   = 32'sd65536;

    typedef logic signed [CW-1:0]     coord_t;
    typedef logic signed [PROJ_W-1:0] proj_t;

    localparam proj_t PROJ_TOP    = {1'b0, {(PROJ_W-1){1'b1}}};
    localparam proj_t PROJ_BOTTOM = {1'b1, {(PROJ_W-1){1'b0}}};

    typedef struct {
        logic [1:0] op;
        coord_t     first_x;
        coord_t     first_y;
        coord_t     first_z;
        coord_t     second_x;
        coord_t     second_y;
        coord_t     second_z;
    } dop_word_t;

    logic clk;
    logic rst_n;

    kd14_in_if #(.COORD_WIDTH(CW)) item_ch ();
    kd14_out_if                    result_ch ();

    kdop14_build_and_aabb_overlap_core #(
        .COORD_WIDTH(CW)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // predicted volume
    proj_t low_bound  [NUM_AXES];
    proj_t high_bound [NUM_AXES];

    bit    expected_overlaps [$];
    int    error_count;
    int    words_sent;
    int    queries_checked;
    int    hits_seen;
    bit    quiet_mode;
    int    stall_left;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("kdop14_build_and_aabb_overlap_core_tb: errors");
        $finish;
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    // axes: x, y, z, x+y+z, x-y+z, x+y-z, x-y-z
    function automatic proj_t project_onto(input int axis, input coord_t x, input coord_t y,
                                           input coord_t z);
        proj_t px;
        proj_t py;
        proj_t pz;
        px = x;
        py = y;
        pz = z;
        case (axis)
            0:       return px;
            1:       return py;
            2:       return pz;
            3:       return px + py + pz;
            4:       return px - py + pz;
            5:       return px + py - pz;
            default: return px - py - pz;
        endcase
    endfunction

    function automatic bit box_overlaps(input dop_word_t w);
        proj_t  lo;
        proj_t  hi;
        proj_t  v;
        coord_t cx;
        coord_t cy;
        coord_t cz;
        bit     hit;
        hit = 1'b1;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (i == 0)
            begin
                lo = w.first_x;
                hi = w.second_x;
            end
            else if (i == 1)
            begin
                lo = w.first_y;
                hi = w.second_y;
            end
            else if (i == 2)
            begin
                lo = w.first_z;
                hi = w.second_z;
            end
            else
            begin
                lo = project_onto(i, w.first_x, w.first_y, w.first_z);
                hi = lo;
                for (int c = 1; c < NUM_CORNERS; c++)
                begin
                    cx = c[2] ? w.second_x : w.first_x;
                    cy = c[1] ? w.second_y : w.first_y;
                    cz = c[0] ? w.second_z : w.first_z;
                    v = project_onto(i, cx, cy, cz);
                    if (v < lo)
                        lo = v;
                    if (v > hi)
                        hi = v;
                end
            end
            if (high_bound[i] < lo || low_bound[i] > hi)
                hit = 1'b0;
        end
        return hit;
    endfunction

    task automatic empty_volume();
        for (int i = 0; i < NUM_AXES; i++)
        begin
            low_bound[i]  = PROJ_TOP;
            high_bound[i] = PROJ_BOTTOM;
        end
    endtask

    task automatic apply_word(input dop_word_t w);
        proj_t v;
        case (w.op)
            OP_CLEAR:
                empty_volume();
            OP_ADD:
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    v = project_onto(i, w.first_x, w.first_y, w.first_z);
                    if (v < low_bound[i])
                        low_bound[i] = v;
                    if (v > high_bound[i])
                        high_bound[i] = v;
                end
            OP_QUERY:
                expected_overlaps.push_back(box_overlaps(w));
            default:
                ;
        endcase
    endtask

    initial
        empty_volume();

    // result check first, then prediction of the word taken at this edge
    always @(posedge clk)
    begin
        dop_word_t w;
        bit        want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_overlaps.size() == 0)
                begin
                    $error("overlap: expected none, actual %0b", result_ch.overlap);
                    error_count++;
                end
                else
                begin
                    want = expected_overlaps.pop_front();
                    queries_checked++;
                    if (result_ch.overlap === 1'b1)
                        hits_seen++;
                    if (result_ch.overlap !== want)
                    begin
                        $error("overlap: expected %0b, actual %0b", want, result_ch.overlap);
                        error_count++;
                    end
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                w.op       = item_ch.opcode;
                w.first_x  = item_ch.first_x;
                w.first_y  = item_ch.first_y;
                w.first_z  = item_ch.first_z;
                w.second_x = item_ch.second_x;
                w.second_y = item_ch.second_y;
                w.second_z = item_ch.second_z;
                apply_word(w);
            end
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else if (!quiet_mode && $urandom_range(0, 99) < 25)
        begin
            stall_left = pick_idle();
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    function automatic dop_word_t make_word(input logic [1:0] op, input coord_t ax,
                                            input coord_t ay, input coord_t az,
                                            input coord_t bx, input coord_t by,
                                            input coord_t bz);
        dop_word_t w;
        w.op       = op;
        w.first_x  = ax;
        w.first_y  = ay;
        w.first_z  = az;
        w.second_x = bx;
        w.second_y = by;
        w.second_z = bz;
        return w;
    endfunction

    function automatic coord_t sat_coord(input longint v);
        if (v > longint'(C_MAX))
            return C_MAX;
        if (v < longint'(C_MIN))
            return C_MIN;
        return coord_t'(v);
    endfunction

    // called at a clock edge; returns at the edge where the word is taken
    task automatic send_word(input dop_word_t w);
        int gap;
        gap = pick_idle();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.opcode   <= w.op;
        item_ch.first_x  <= w.first_x;
        item_ch.first_y  <= w.first_y;
        item_ch.first_z  <= w.first_z;
        item_ch.second_x <= w.second_x;
        item_ch.second_y <= w.second_y;
        item_ch.second_z <= w.second_z;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic test_empty_volume();
        send_word(make_word(OP_QUERY, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
        send_word(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_QUERY, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
    endtask

    task automatic test_extreme_points();
        send_word(make_word(OP_ADD, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN));
        send_word(make_word(OP_ADD, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
        send_word(make_word(OP_QUERY, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_QUERY, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
        send_word(make_word(OP_QUERY, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
        // x interval upside down
        send_word(make_word(OP_QUERY, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX));
    endtask

    task automatic test_touching_and_inverted();
        send_word(make_word(OP_CLEAR, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN));
        send_word(make_word(OP_ADD, ONE, 2 * ONE, 3 * ONE, 0, 0, 0));
        send_word(make_word(OP_QUERY, ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE));
        send_word(make_word(OP_QUERY, ONE + 1, 0, 0, 5 * ONE, 5 * ONE, 5 * ONE));
        send_word(make_word(OP_QUERY, -5 * ONE, 0, 0, ONE, 5 * ONE, 5 * ONE));
        // unused opcode leaves the volume alone
        send_word(make_word(OP_UNUSED, C_MIN, C_MAX, 0, -1, C_MAX, C_MIN));
        send_word(make_word(OP_QUERY, ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE));
        send_word(make_word(OP_QUERY, 5 * ONE, 5 * ONE, 5 * ONE, -5 * ONE, -5 * ONE,
                            -5 * ONE));
    endtask

    // one box clear of the triangle only along x+y+z and x+y-z, one box overlapping it
    task automatic test_diagonal_separation();
        send_word(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_ADD, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_ADD, ONE, 0, 0, 0, 0, 0));
        send_word(make_word(OP_ADD, 0, ONE, 0, 0, 0, 0));
        send_word(make_word(OP_QUERY, 32'sd52429, 32'sd52429, 0, ONE, ONE, 0));
        send_word(make_word(OP_QUERY, 32'sd26214, 32'sd26214, 0, ONE, ONE, 0));
    endtask

    function automatic coord_t vertex_coord(input longint centre, input longint span);
        if ($urandom_range(0, 9) == 0)
            return coord_t'($urandom);
        return sat_coord(centre + longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic test_random_triangles();
        longint    span;
        longint    cx;
        longint    cy;
        longint    cz;
        longint    hx;
        longint    hy;
        longint    hz;
        coord_t    lo_c [3];
        coord_t    hi_c [3];
        coord_t    tmp;
        dop_word_t w;
        int        n_add;
        int        n_query;
        int        axis;
        int        target;
        target = words_sent + RANDOM_WORDS - 45;
        while (words_sent < target)
        begin
            // runs of back-to-back traffic every so often
            quiet_mode = ($urandom_range(0, 7) == 0);
            span = longint'(1) << $urandom_range(4, 29);
            if ($urandom_range(0, 3) == 0)
            begin
                cx = 0;
                cy = 0;
                cz = 0;
            end
            else
            begin
                cx = longint'($urandom_range(0, 32'h7fff_ffff)) - 64'sh4000_0000;
                cy = longint'($urandom_range(0, 32'h7fff_ffff)) - 64'sh4000_0000;
                cz = longint'($urandom_range(0, 32'h7fff_ffff)) - 64'sh4000_0000;
            end
            if ($urandom_range(0, 9) != 0)
                send_word(make_word(OP_CLEAR, coord_t'($urandom), coord_t'($urandom),
                                    coord_t'($urandom), coord_t'($urandom),
                                    coord_t'($urandom), coord_t'($urandom)));
            n_add = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 3;
            for (int k = 0; k < n_add; k++)
                send_word(make_word(OP_ADD, vertex_coord(cx, span), vertex_coord(cy, span),
                                    vertex_coord(cz, span), coord_t'($urandom),
                                    coord_t'($urandom), coord_t'($urandom)));
            if ($urandom_range(0, 9) == 0)
                send_word(make_word(OP_UNUSED, coord_t'($urandom), coord_t'($urandom),
                                    coord_t'($urandom), coord_t'($urandom),
                                    coord_t'($urandom), coord_t'($urandom)));
            n_query = $urandom_range(1, 4);
            for (int k = 0; k < n_query; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    w = make_word(OP_QUERY, coord_t'($urandom), coord_t'($urandom),
                                  coord_t'($urandom), coord_t'($urandom),
                                  coord_t'($urandom), coord_t'($urandom));
                else
                begin
                    hx = $urandom_range(0, span);
                    hy = $urandom_range(0, span);
                    hz = $urandom_range(0, span);
                    lo_c[0] = vertex_coord(cx, 2 * span);
                    lo_c[1] = vertex_coord(cy, 2 * span);
                    lo_c[2] = vertex_coord(cz, 2 * span);
                    hi_c[0] = sat_coord(longint'(lo_c[0]) + hx);
                    hi_c[1] = sat_coord(longint'(lo_c[1]) + hy);
                    hi_c[2] = sat_coord(longint'(lo_c[2]) + hz);
                    if ($urandom_range(0, 9) == 0)
                    begin
                        axis = $urandom_range(0, 2);
                        tmp = lo_c[axis];
                        lo_c[axis] = hi_c[axis];
                        hi_c[axis] = tmp;
                    end
                    w = make_word(OP_QUERY, lo_c[0], lo_c[1], lo_c[2],
                                  hi_c[0], hi_c[1], hi_c[2]);
                end
                send_word(w);
            end
        end
        quiet_mode = 1'b0;
    endtask

    task automatic test_random_noise();
        for (int k = 0; k < 45; k++)
            send_word(make_word(2'($urandom_range(0, 3)), coord_t'($urandom),
                                coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                                coord_t'($urandom), coord_t'($urandom)));
    endtask

    initial
    begin
        rst_n            = 1'b0;
        item_ch.valid    = 1'b0;
        item_ch.opcode   = OP_CLEAR;
        item_ch.first_x  = '0;
        item_ch.first_y  = '0;
        item_ch.first_z  = '0;
        item_ch.second_x = '0;
        item_ch.second_y = '0;
        item_ch.second_z = '0;
        result_ch.ready  = 1'b0;
        error_count      = 0;
        words_sent       = 0;
        queries_checked  = 0;
        hits_seen        = 0;
        quiet_mode       = 1'b0;
        stall_left       = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_volume();
        test_extreme_points();
        test_touching_and_inverted();
        test_diagonal_separation();
        test_random_triangles();
        test_random_noise();

        item_ch.valid <= 1'b0;
        while (expected_overlaps.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("sent %0d words (clear, add, query, unused opcode); checked %0d overlap results,",
                 words_sent, queries_checked);
        $display("%0d of them hits, under random gaps and back-pressure on both sides", hits_seen);
        if (error_count == 0)
            $display("kdop14_build_and_aabb_overlap_core_tb: clean");
        else
            $display("kdop14_build_and_aabb_overlap_core_tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
src/kd14_pkg.sv
src/kd14_if.sv
src/kd14_proj.sv
src/kd14_bounds.sv
src/kdop14_build_and_aabb_overlap_core.sv
bench/kdop14_build_and_aabb_overlap_core_tb.sv
